### hdl/pce_pkg.sv
// ----------------------------------------------------------------------------
// pce_pkg
// Types and constants shared by the punctured convolutional encoder files.
// ----------------------------------------------------------------------------
package pce_pkg;

  // Fixed widths of the configuration registers.
  localparam int GEN_W  = 9;
  localparam int CL_W   = 4;
  localparam int PAT_W  = 16;
  localparam int PER_W  = 5;

  // Register file bus.
  localparam int DATA_W = 32;
  localparam int ADDR_W = 5;

  // Reset values of the registers.
  localparam logic [GEN_W-1:0] GEN_X_RST  = 9'd91;
  localparam logic [GEN_W-1:0] GEN_Y_RST  = 9'd121;
  localparam logic [CL_W-1:0]  CL_RST     = 4'd7;
  localparam logic [PAT_W-1:0] PUNC_X_RST = 16'd1;
  localparam logic [PAT_W-1:0] PUNC_Y_RST = 16'd1;
  localparam logic [PER_W-1:0] PERIOD_RST = 5'd1;

  // Register indexes (byte address is four times the index).
  typedef enum logic [2:0] {
    REG_GEN_X   = 3'd0,
    REG_GEN_Y   = 3'd1,
    REG_CL      = 3'd2,
    REG_PUNC_X  = 3'd3,
    REG_PUNC_Y  = 3'd4,
    REG_PERIOD  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [GEN_W-1:0] gen_poly_x;
    logic [GEN_W-1:0] gen_poly_y;
    logic [CL_W-1:0]  constraint_length;
    logic [PAT_W-1:0] puncture_x;
    logic [PAT_W-1:0] puncture_y;
    logic [PER_W-1:0] puncture_period;
  } cfg_t;

  typedef struct packed {
    logic data_bit;
    logic block_start;
    logic clear_register;
  } in_word_t;

  typedef struct packed {
    logic coded_bit;
    logic is_second;
    logic last_of_run;
  } out_word_t;

  // Encoder result for one data bit: both parities and which survive.
  typedef struct packed {
    logic x_bit;
    logic y_bit;
    logic take_x;
    logic take_y;
  } enc_res_t;

endpackage

### hdl/pce_encode.sv
// ----------------------------------------------------------------------------
// pce_encode
// Combinational encoder step: forms the code word, both parities, the
// puncture decision and the next shift register and phase.
// ----------------------------------------------------------------------------
module pce_encode #(
  parameter int MAX_CONSTRAINT = 9,
  parameter int MAX_PERIOD     = 16,
  localparam int SR_W = MAX_CONSTRAINT - 1,
  localparam int PH_W = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1
) (
  input  pce_pkg::cfg_t     cfg,
  input  pce_pkg::in_word_t item,
  input  logic [SR_W-1:0]   shift_q,
  input  logic [PH_W-1:0]   phase_q,
  output pce_pkg::enc_res_t res,
  output logic [SR_W-1:0]   shift_d,
  output logic [PH_W-1:0]   phase_d
);

  localparam int KW_A = $clog2(MAX_CONSTRAINT + 1);
  localparam int KW   = (KW_A > pce_pkg::CL_W) ? KW_A : pce_pkg::CL_W;
  localparam int GW   = (MAX_CONSTRAINT > pce_pkg::GEN_W) ? MAX_CONSTRAINT : pce_pkg::GEN_W;
  localparam int WP_A = $clog2(MAX_PERIOD + 1);
  localparam int WP   = (WP_A > pce_pkg::PER_W) ? WP_A : pce_pkg::PER_W;
  localparam int PXW  = 2 ** WP;

  logic [KW-1:0]             k_ext;
  logic [KW-1:0]             k_eff;
  logic [MAX_CONSTRAINT-1:0] sr_ext;
  logic [MAX_CONSTRAINT-1:0] word;
  logic [GW-1:0]             gx;
  logic [GW-1:0]             gy;
  logic [WP-1:0]             p_ext;
  logic [WP-1:0]             per_eff;
  logic [WP-1:0]             ph_ext;
  logic [WP-1:0]             ph_use;
  logic [WP-1:0]             ph_inc;
  logic [WP-1:0]             sel;
  logic [PXW-1:0]            px;
  logic [PXW-1:0]            py;

  // Code word: the data bit sits at position k-1, register bits below it.
  always_comb begin
    k_ext = KW'(cfg.constraint_length);
    if (k_ext < KW'(2)) begin
      k_eff = KW'(2);
    end else if (k_ext > KW'(MAX_CONSTRAINT)) begin
      k_eff = KW'(MAX_CONSTRAINT);
    end else begin
      k_eff = k_ext;
    end
    sr_ext = item.clear_register ? '0 : {1'b0, shift_q};
    for (int i = 0; i < MAX_CONSTRAINT; i++) begin
      if (KW'(i) == k_eff - KW'(1)) begin
        word[i] = item.data_bit;
      end else if (KW'(i) < k_eff - KW'(1)) begin
        word[i] = sr_ext[i];
      end else begin
        word[i] = 1'b0;
      end
    end
  end

  assign gx        = GW'(cfg.gen_poly_x);
  assign gy        = GW'(cfg.gen_poly_y);
  assign res.x_bit = ^(word & gx[MAX_CONSTRAINT-1:0]);
  assign res.y_bit = ^(word & gy[MAX_CONSTRAINT-1:0]);
  assign shift_d   = word[MAX_CONSTRAINT-1:1];

  // Puncture phase and pattern selection; the first position uses the
  // most significant bit of the period.
  always_comb begin
    p_ext = WP'(cfg.puncture_period);
    if (p_ext == '0) begin
      per_eff = WP'(1);
    end else if (p_ext > WP'(MAX_PERIOD)) begin
      per_eff = WP'(MAX_PERIOD);
    end else begin
      per_eff = p_ext;
    end
    ph_ext = WP'(phase_q);
    if (item.block_start || (ph_ext >= per_eff)) begin
      ph_use = '0;
    end else begin
      ph_use = ph_ext;
    end
    sel    = per_eff - ph_use - WP'(1);
    ph_inc = ph_use + WP'(1);
    if (ph_inc >= per_eff) begin
      phase_d = '0;
    end else begin
      phase_d = ph_inc[PH_W-1:0];
    end
  end

  assign px         = PXW'(cfg.puncture_x);
  assign py         = PXW'(cfg.puncture_y);
  assign res.take_x = px[sel];
  assign res.take_y = py[sel];

endmodule

### hdl/punctured_convolutional_encoder_core.sv
// ----------------------------------------------------------------------------
// punctured_convolutional_encoder_core
// Rate-1/2 convolutional encoder with a programmable puncture pattern.
// ----------------------------------------------------------------------------
// Each input word carries one data bit and gives zero, one or two coded bit
// words: the X parity first, then the Y parity, each only when its puncture
// pattern bit for the current phase is set. An accepted word lands in an
// input register; once the result register is free, the encoder logic
// moves it into a two-entry result register, and the coded bits leave from
// there one per cycle while the receiver does not stall. The input register
// refills in the same cycle it hands off, so a data bit can be taken every
// cycle while each yields at most one coded bit; when both X and Y survive,
// the next data bit waits until the Y bit leaves: the one-bit result
// channel and its two-entry result register set that rate. Words that are
// fully punctured still advance the shift register and phase but produce
// nothing. The last coded bit of each data bit carries last_of_run.
// Registers are written through the APB port at byte address four times
// their index and must only be changed while the block is idle.
// ----------------------------------------------------------------------------
module punctured_convolutional_encoder_core #(
  parameter int MAX_CONSTRAINT = 9,
  parameter int MAX_PERIOD     = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pce_pkg::in_word_t           in_data,
  // Result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output pce_pkg::out_word_t          out_data,
  // Register port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [pce_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [pce_pkg::DATA_W-1:0]  cfg_pwdata,
  output logic [pce_pkg::DATA_W-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int SR_W = MAX_CONSTRAINT - 1;
  localparam int PH_W = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;

  // Register file.
  pce_pkg::cfg_t     cfg_r;
  pce_pkg::reg_idx_t reg_sel;
  logic              cfg_wr;

  // Input register.
  logic              in_vld_r;
  logic              in_vld_nxt;
  pce_pkg::in_word_t in_r;
  logic              in_take;

  // Encoder state.
  logic [SR_W-1:0]   shift_r;
  logic [SR_W-1:0]   shift_nxt;
  logic [PH_W-1:0]   phase_r;
  logic [PH_W-1:0]   phase_nxt;
  pce_pkg::enc_res_t enc;

  // Result register: X and Y slots with their own valid bits.
  logic              vx_r;
  logic              vx_nxt;
  logic              vy_r;
  logic              vy_nxt;
  logic              xb_r;
  logic              yb_r;
  logic              out_take;
  logic              res_free;
  logic              adv;

  // --------------------------------------------------------------------------
  // Register port. pready is always high, so a write lands in the access
  // cycle. The low address bits select nothing.
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign reg_sel    = pce_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gen_poly_x        <= pce_pkg::GEN_X_RST;
      cfg_r.gen_poly_y        <= pce_pkg::GEN_Y_RST;
      cfg_r.constraint_length <= pce_pkg::CL_RST;
      cfg_r.puncture_x        <= pce_pkg::PUNC_X_RST;
      cfg_r.puncture_y        <= pce_pkg::PUNC_Y_RST;
      cfg_r.puncture_period   <= pce_pkg::PERIOD_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        pce_pkg::REG_GEN_X:  cfg_r.gen_poly_x        <= cfg_pwdata[pce_pkg::GEN_W-1:0];
        pce_pkg::REG_GEN_Y:  cfg_r.gen_poly_y        <= cfg_pwdata[pce_pkg::GEN_W-1:0];
        pce_pkg::REG_CL:     cfg_r.constraint_length <= cfg_pwdata[pce_pkg::CL_W-1:0];
        pce_pkg::REG_PUNC_X: cfg_r.puncture_x        <= cfg_pwdata[pce_pkg::PAT_W-1:0];
        pce_pkg::REG_PUNC_Y: cfg_r.puncture_y        <= cfg_pwdata[pce_pkg::PAT_W-1:0];
        pce_pkg::REG_PERIOD: cfg_r.puncture_period   <= cfg_pwdata[pce_pkg::PER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      pce_pkg::REG_GEN_X:  cfg_prdata = pce_pkg::DATA_W'(cfg_r.gen_poly_x);
      pce_pkg::REG_GEN_Y:  cfg_prdata = pce_pkg::DATA_W'(cfg_r.gen_poly_y);
      pce_pkg::REG_CL:     cfg_prdata = pce_pkg::DATA_W'(cfg_r.constraint_length);
      pce_pkg::REG_PUNC_X: cfg_prdata = pce_pkg::DATA_W'(cfg_r.puncture_x);
      pce_pkg::REG_PUNC_Y: cfg_prdata = pce_pkg::DATA_W'(cfg_r.puncture_y);
      pce_pkg::REG_PERIOD: cfg_prdata = pce_pkg::DATA_W'(cfg_r.puncture_period);
      default:             cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake. The result register is free for the next word when it is
  // empty or when its last entry leaves this cycle. The input register hands
  // off into it and can take a new word in the same cycle.
  // --------------------------------------------------------------------------
  assign out_valid  = vx_r || vy_r;
  assign out_take   = out_valid && !out_stall;
  assign res_free   = !out_valid || (out_take && !(vx_r && vy_r));
  assign adv        = in_vld_r && res_free;
  assign in_stall   = in_vld_r && !res_free;
  assign in_take    = in_valid && !in_stall;
  assign in_vld_nxt = in_take || (in_vld_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r <= in_data;
    end
  end

  // --------------------------------------------------------------------------
  // Encoder step between the input register and the result register.
  // --------------------------------------------------------------------------
  pce_encode #(
    .MAX_CONSTRAINT (MAX_CONSTRAINT),
    .MAX_PERIOD     (MAX_PERIOD)
  ) u_encode (
    .cfg     (cfg_r),
    .item    (in_r),
    .shift_q (shift_r),
    .phase_q (phase_r),
    .res     (enc),
    .shift_d (shift_nxt),
    .phase_d (phase_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      phase_r <= '0;
    end else if (adv) begin
      shift_r <= shift_nxt;
      phase_r <= phase_nxt;
    end
  end

  // X always leaves before Y; a new word refills both slots.
  always_comb begin
    vx_nxt = vx_r;
    vy_nxt = vy_r;
    if (out_take) begin
      if (vx_r) begin
        vx_nxt = 1'b0;
      end else begin
        vy_nxt = 1'b0;
      end
    end
    if (adv) begin
      vx_nxt = enc.take_x;
      vy_nxt = enc.take_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r <= 1'b0;
      vy_r <= 1'b0;
    end else begin
      vx_r <= vx_nxt;
      vy_r <= vy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xb_r <= enc.x_bit;
      yb_r <= enc.y_bit;
    end
  end

  always_comb begin
    if (vx_r) begin
      out_data.coded_bit   = xb_r;
      out_data.is_second   = 1'b0;
      out_data.last_of_run = !vy_r;
    end else begin
      out_data.coded_bit   = yb_r;
      out_data.is_second   = 1'b1;
      out_data.last_of_run = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Checks.
  // --------------------------------------------------------------------------
  // Once X of a pair leaves, the Y bit of the same word is shown next.
  a_y_follows_x: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && vx_r && vy_r) |=> (vy_r && !vx_r && $stable(yb_r)))
    else $error("Y bit did not follow its X bit");

  // A new word is only taken when the input register is empty or hands off.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> (!in_vld_r || adv))
    else $error("input register overwritten");

  // The phase stays inside the largest pattern.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(phase_r) < 32'(MAX_PERIOD)) || (MAX_PERIOD == 1))
    else $error("puncture phase out of range");

  // Encoder state only moves when a word passes into the result register.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && !$past(!rst_n)) |=> ($stable(shift_r) && $stable(phase_r)))
    else $error("encoder state changed without a word");

endmodule

### sim/punctured_convolutional_encoder_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// punctured_convolutional_encoder_core_tb
// Self-checking bench for the punctured rate-1/2 convolutional encoder.
// ----------------------------------------------------------------------------
// A behavioral encoder in this file follows every accepted data word and
// queues the coded bit words it should produce. A monitor pops that queue
// on each coded bit accepted from the block and compares every field. The
// register settings are changed over the APB port only while the block is
// drained. A short directed part covers the register extremes, clamped
// settings, full puncturing and a period that shrinks under a running phase.
// It is followed by random block-structured traffic under three idle mixes.
// ----------------------------------------------------------------------------
module punctured_convolutional_encoder_core_tb;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_TAIL  = 6;     // slack for fully punctured words to retire
  localparam int MAX_REPORTS  = 40;

  logic                         clk;
  logic                         rst_n       = 1'b0;
  logic                         in_valid    = 1'b0;
  logic                         in_stall;
  pce_pkg::in_word_t            in_data     = '0;
  logic                         out_valid;
  logic                         out_stall   = 1'b0;
  pce_pkg::out_word_t           out_data;
  logic                         cfg_psel    = 1'b0;
  logic                         cfg_penable = 1'b0;
  logic                         cfg_pwrite  = 1'b0;
  logic [pce_pkg::ADDR_W-1:0]   cfg_paddr   = '0;
  logic [pce_pkg::DATA_W-1:0]   cfg_pwdata  = '0;
  logic [pce_pkg::DATA_W-1:0]   cfg_prdata;
  logic                         cfg_pready;

  punctured_convolutional_encoder_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Encoder state as the bench sees it: register settings, the shift
  // register and the puncture phase.
  pce_pkg::cfg_t        enc_cfg;
  logic [7:0]           enc_sreg;
  int unsigned          enc_phase;

  // Coded bit words still owed by the block, oldest first.
  pce_pkg::out_word_t   coded_q[$];

  int          mismatches    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          cycle_count   = 0;

  // Work out the coded bits for one accepted data word and queue them.
  function automatic void encode_bit(pce_pkg::in_word_t w);
    int unsigned k;
    int unsigned per;
    int unsigned sel;
    logic [8:0]  reg_mask;
    logic [8:0]  word;
    logic        x_par;
    logic        y_par;
    logic        take_x;
    logic        take_y;
    k = enc_cfg.constraint_length;
    if (k < 2) k = 2;
    if (k > 9) k = 9;
    per = enc_cfg.puncture_period;
    if (per < 1) per = 1;
    if (per > 16) per = 16;

    // The new bit sits just above the k-1 register bits that are in use.
    if (w.clear_register) enc_sreg = '0;
    reg_mask = 9'((1 << (k - 1)) - 1);
    word     = (9'(w.data_bit) << (k - 1)) | ({1'b0, enc_sreg} & reg_mask);
    x_par    = ^(word & enc_cfg.gen_poly_x);
    y_par    = ^(word & enc_cfg.gen_poly_y);
    enc_sreg = word[8:1];

    // A phase left beyond a shortened period restarts like a block start.
    if (w.block_start || enc_phase >= per) enc_phase = 0;
    sel    = per - enc_phase - 1;
    take_x = enc_cfg.puncture_x[sel];
    take_y = enc_cfg.puncture_y[sel];
    enc_phase++;
    if (enc_phase >= per) enc_phase = 0;

    if (take_x)
      coded_q.push_back('{coded_bit: x_par, is_second: 1'b0, last_of_run: !take_y});
    if (take_y)
      coded_q.push_back('{coded_bit: y_par, is_second: 1'b1, last_of_run: 1'b1});
  endfunction

  function automatic void check_field(string fname, logic want_v, logic got_v);
    if (want_v !== got_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0b, actual %0b",
                 $time, fname, want_v, got_v);
    end
  endfunction

  // Coded bit monitor: every word taken from the block must match the oldest
  // queued prediction.
  always @(posedge clk) begin
    pce_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (coded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected coded word, expected none, actual %b",
                   $time, out_data);
      end else begin
        want = coded_q.pop_front();
        check_field("coded_bit", want.coded_bit, out_data.coded_bit);
        check_field("is_second", want.is_second, out_data.is_second);
        check_field("last_of_run", want.last_of_run, out_data.last_of_run);
      end
    end
  end

  // Receiver back-pressure, at the rate of the current idle mix.
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("punctured_convolutional_encoder_core_tb failed");
      $finish;
    end
  end

  // Present one data word and hold it until the block takes it. in_valid is
  // left high afterwards; the next send or a settle decides what follows.
  task automatic send_bit(pce_pkg::in_word_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
    encode_bit(w);
  endtask

  // Stop sending and wait until every owed coded word is back, then give
  // the pipeline time to retire words that were fully punctured.
  task automatic settle();
    in_valid <= 1'b0;
    while (coded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TAIL) @(posedge clk);
  endtask

  // One APB write. psel stays high so back-to-back writes go straight from
  // access to the next setup; program_regs drops it after the last one.
  task automatic write_reg(pce_pkg::reg_idx_t idx, logic [pce_pkg::DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
  endtask

  // Write all six registers; the block must already be drained.
  task automatic program_regs(pce_pkg::cfg_t c);
    write_reg(pce_pkg::REG_GEN_X,  pce_pkg::DATA_W'(c.gen_poly_x));
    write_reg(pce_pkg::REG_GEN_Y,  pce_pkg::DATA_W'(c.gen_poly_y));
    write_reg(pce_pkg::REG_CL,     pce_pkg::DATA_W'(c.constraint_length));
    write_reg(pce_pkg::REG_PUNC_X, pce_pkg::DATA_W'(c.puncture_x));
    write_reg(pce_pkg::REG_PUNC_Y, pce_pkg::DATA_W'(c.puncture_y));
    write_reg(pce_pkg::REG_PERIOD, pce_pkg::DATA_W'(c.puncture_period));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    enc_cfg = c;
  endtask

  task automatic reconfigure(pce_pkg::cfg_t c);
    settle();
    program_regs(c);
  endtask

  // Reset settings: K=7, generators 91 and 121, no puncturing.
  task automatic test_reset_defaults();
    send_bit('{data_bit: 1'b1, block_start: 1'b1, clear_register: 1'b1});
    send_bit('{data_bit: 1'b0, block_start: 1'b0, clear_register: 1'b0});
    send_bit('{data_bit: 1'b1, block_start: 1'b0, clear_register: 1'b0});
    send_bit('{data_bit: 1'b1, block_start: 1'b0, clear_register: 1'b1});
  endtask

  // Full and empty generators at the longest constraint, with a two-bit
  // pattern that keeps only X first and only Y second.
  task automatic test_generator_extremes();
    reconfigure('{gen_poly_x: 9'h1FF, gen_poly_y: 9'h000, constraint_length: 4'd9,
                  puncture_x: 16'h0002, puncture_y: 16'h0001,
                  puncture_period: 5'd2});
    send_bit('{data_bit: 1'b1, block_start: 1'b1, clear_register: 1'b0});
    send_bit('{data_bit: 1'b1, block_start: 1'b0, clear_register: 1'b0});
    send_bit('{data_bit: 1'b0, block_start: 1'b0, clear_register: 1'b0});
    send_bit('{data_bit: 1'b1, block_start: 1'b1, clear_register: 1'b0});
  endtask

  // Constraint lengths and periods outside the legal range clamp.
  task automatic test_clamped_settings();
    reconfigure('{gen_poly_x: 9'h000, gen_poly_y: 9'h1FF, constraint_length: 4'd0,
                  puncture_x: 16'h0000, puncture_y: 16'h0001,
                  puncture_period: 5'd0});
    send_bit('{data_bit: 1'b1, block_start: 1'b0, clear_register: 1'b0});
    send_bit('{data_bit: 1'b0, block_start: 1'b0, clear_register: 1'b0});
    send_bit('{data_bit: 1'b1, block_start: 1'b0, clear_register: 1'b0});
    reconfigure('{gen_poly_x: 9'h155, gen_poly_y: 9'h0AA, constraint_length: 4'd15,
                  puncture_x: 16'hFFFF, puncture_y: 16'hFFFF,
                  puncture_period: 5'd31});
    send_bit('{data_bit: 1'b1, block_start: 1'b1, clear_register: 1'b1});
    send_bit('{data_bit: 1'b1, block_start: 1'b0, clear_register: 1'b0});
    send_bit('{data_bit: 1'b0, block_start: 1'b0, clear_register: 1'b0});
  endtask

  // Both pattern bits clear: nothing comes out, yet register and phase move.
  task automatic test_full_puncture();
    reconfigure('{gen_poly_x: 9'h05B, gen_poly_y: 9'h079, constraint_length: 4'd5,
                  puncture_x: 16'h0000, puncture_y: 16'h0000,
                  puncture_period: 5'd16});
    send_bit('{data_bit: 1'b1, block_start: 1'b1, clear_register: 1'b0});
    send_bit('{data_bit: 1'b0, block_start: 1'b0, clear_register: 1'b0});
    send_bit('{data_bit: 1'b1, block_start: 1'b0, clear_register: 1'b0});
  endtask

  // The phase is left deep in a long pattern, then the period is cut below
  // it, so the next bit must restart the pattern on its own.
  task automatic test_period_shrink();
    reconfigure('{gen_poly_x: 9'h05B, gen_poly_y: 9'h079, constraint_length: 4'd5,
                  puncture_x: 16'hA5C3, puncture_y: 16'h5A3C,
                  puncture_period: 5'd16});
    repeat (5) send_bit('{data_bit: 1'($urandom_range(1)), block_start: 1'b0,
                          clear_register: 1'b0});
    reconfigure('{gen_poly_x: 9'h05B, gen_poly_y: 9'h079, constraint_length: 4'd5,
                  puncture_x: 16'h0006, puncture_y: 16'h0003,
                  puncture_period: 5'd3});
    send_bit('{data_bit: 1'b1, block_start: 1'b0, clear_register: 1'b0});
    send_bit('{data_bit: 1'b0, block_start: 1'b0, clear_register: 1'b0});
  endtask

  function automatic pce_pkg::cfg_t random_settings();
    pce_pkg::cfg_t c;
    c.gen_poly_x = 9'($urandom_range(511));
    c.gen_poly_y = 9'($urandom_range(511));
    if ($urandom_range(9) == 0)
      c.constraint_length = 4'($urandom_range(15));
    else
      c.constraint_length = 4'($urandom_range(9, 2));
    if ($urandom_range(9) == 0)
      c.puncture_period = 5'($urandom_range(31));
    else
      c.puncture_period = 5'($urandom_range(16, 1));
    c.puncture_x = 16'($urandom);
    c.puncture_y = 16'($urandom);
    // Now and then force an all-kept or all-dropped pattern.
    case ($urandom_range(9))
      0: c.puncture_x = 16'hFFFF;
      1: c.puncture_y = 16'h0000;
      default: ;
    endcase
    return c;
  endfunction

  // Random traffic under one idle mix: segments of about fifty words, each
  // with fresh settings. Most words form blocks that open with block_start
  // (usually with a register clear); the rest are words with random flags.
  task automatic test_random_traffic(int n_items, int s_pct, int r_pct);
    int                sent;
    int                seg_sent;
    int                block_len;
    int                seg;
    bit                paused;
    pce_pkg::in_word_t w;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    seg  = 0;
    while (sent < n_items) begin
      reconfigure(random_settings());
      seg_sent = 0;
      paused   = 1'b0;
      while (seg_sent < 50 && sent < n_items) begin
        // In the first segment, else one time in four, let the block drain.
        if (!paused && seg_sent >= 25) begin
          paused = 1'b1;
          if (seg == 0 || $urandom_range(3) == 0) settle();
        end
        if ($urandom_range(99) < 15) begin
          w = 3'($urandom_range(7));
          send_bit(w);
          seg_sent++;
          sent++;
        end else begin
          block_len = $urandom_range(34, 1);
          for (int i = 0; i < block_len; i++) begin
            w.data_bit       = 1'($urandom_range(1));
            w.block_start    = (i == 0);
            w.clear_register = (i == 0) && ($urandom_range(9) < 7);
            send_bit(w);
            seg_sent++;
            sent++;
          end
        end
      end
      seg++;
    end
  endtask

  initial begin
    enc_cfg.gen_poly_x        = pce_pkg::GEN_X_RST;
    enc_cfg.gen_poly_y        = pce_pkg::GEN_Y_RST;
    enc_cfg.constraint_length = pce_pkg::CL_RST;
    enc_cfg.puncture_x        = pce_pkg::PUNC_X_RST;
    enc_cfg.puncture_y        = pce_pkg::PUNC_Y_RST;
    enc_cfg.puncture_period   = pce_pkg::PERIOD_RST;
    enc_sreg  = '0;
    enc_phase = 0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_generator_extremes();
    test_clamped_settings();
    test_full_puncture();
    test_period_shrink();

    // Receiver-heavy idling, then sender-heavy, then none at all.
    test_random_traffic(350, 21, 48);
    test_random_traffic(350, 48, 21);
    test_random_traffic(350, 0, 0);

    settle();
    if (mismatches == 0) begin
      $display("punctured_convolutional_encoder_core_tb passed");
    end else begin
      $display("punctured_convolutional_encoder_core_tb failed");
    end
    $finish;
  end

endmodule
